>>> hw/rtl/tcpw_pkg.sv
// Shared types, constants and helpers for the text cell priority writer.
`default_nettype none

package tcpw_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int COL_IDX_W   = $clog2(MAX_COLUMNS);
  localparam int ROW_IDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COLS_W      = $clog2(MAX_COLUMNS + 1);
  localparam int ROWS_W      = $clog2(MAX_ROWS + 1);
  localparam int CMP_W       = 9;
  localparam int CUR_W       = 17;

  localparam logic [15:0]        SPACE_CODE = 16'h0020;
  localparam logic [15:0]        WIDE_ABOVE = 16'd127;
  localparam logic signed [15:0] CLEAR_PRIO = -16'sd1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_TRAIL,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               run_start;
    logic signed [15:0] column;
    logic signed [15:0] row;
    logic [15:0]        char_code;
    logic [3:0]         foreground;
    logic [3:0]         background;
    logic signed [15:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [15:0]        cell_char;
    logic [3:0]         cell_foreground;
    logic [3:0]         cell_background;
    logic               cell_leading;
    logic               cell_trailing;
    logic signed [15:0] cell_priority;
  } rsp_t;

  typedef struct packed {
    logic [15:0]        char_code;
    logic               trailing;
    logic               leading;
    logic [3:0]         background;
    logic [3:0]         foreground;
    logic signed [15:0] prio;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef struct packed {
    logic [COLS_W-1:0] eff_cols;
    logic [ROWS_W-1:0] eff_rows;
  } size_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    cell_t             wdata;
  } mem_req_t;

  function automatic cell_t cleared_cell();
    cell_t c;
    c            = '0;
    c.char_code  = SPACE_CODE;
    c.prio       = CLEAR_PRIO;
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_IDX_W-1:0] r,
                                                   input logic [COL_IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tcpw_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module tcpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcpw_cfg.sv
// Screen size registers and the clipped sizes in effect.
`default_nettype none

module tcpw_cfg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire tcpw_pkg::cfg_reg_t cfg_index,
  input  wire logic [7:0]         cfg_data,
  output tcpw_pkg::size_t         size
);

  logic [7:0] screen_columns;
  logic [6:0] screen_rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= 8'd80;
      screen_rows    <= 7'd25;
    end else if (cfg_valid) begin
      case (cfg_index)
        tcpw_pkg::REG_COLUMNS: screen_columns <= cfg_data;
        tcpw_pkg::REG_ROWS:    screen_rows    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Clip to the size of the store.
  always_comb begin
    if (tcpw_pkg::CMP_W'(screen_columns) < tcpw_pkg::CMP_W'(tcpw_pkg::MAX_COLUMNS)) begin
      size.eff_cols = tcpw_pkg::COLS_W'(screen_columns);
    end else begin
      size.eff_cols = tcpw_pkg::COLS_W'(tcpw_pkg::MAX_COLUMNS);
    end
    if (tcpw_pkg::CMP_W'(screen_rows) < tcpw_pkg::CMP_W'(tcpw_pkg::MAX_ROWS)) begin
      size.eff_rows = tcpw_pkg::ROWS_W'(screen_rows);
    end else begin
      size.eff_rows = tcpw_pkg::ROWS_W'(tcpw_pkg::MAX_ROWS);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcpw_ctrl.sv
// Request sequencer: run cursor, priority read-modify-write, clear sweep and reads.
`default_nettype none

module tcpw_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire tcpw_pkg::req_t            req,
  output logic                           busy,
  input  wire tcpw_pkg::size_t           size,
  output tcpw_pkg::mem_req_t             mem_req,
  input  wire logic [tcpw_pkg::CELL_W-1:0] mem_rdata,
  output logic                           result_valid,
  output tcpw_pkg::rsp_t                 result
);

  tcpw_pkg::state_t                       state, state_next;
  logic [tcpw_pkg::ADDR_W-1:0]            clr_addr;
  logic signed [tcpw_pkg::CUR_W-1:0]      cursor;
  logic [tcpw_pkg::ROW_IDX_W-1:0]         run_row;
  logic                                   run_live;
  logic [tcpw_pkg::ADDR_W-1:0]            wr_addr;
  tcpw_pkg::cell_t                        wr_cell;
  logic                                   wr_wide;
  logic                                   rd_oor;

  logic                                   accept;
  logic signed [tcpw_pkg::CUR_W-1:0]      cur;
  logic signed [tcpw_pkg::CUR_W-1:0]      cur_step;
  logic                                   start_live;
  logic                                   live;
  logic [tcpw_pkg::ROW_IDX_W-1:0]         row_idx;
  logic                                   is_wide;
  logic                                   at_edge;
  logic                                   row_ok;
  logic                                   fits;
  logic                                   put;
  logic                                   read_ok;
  logic [tcpw_pkg::ADDR_W-1:0]            draw_addr;
  logic [tcpw_pkg::ADDR_W-1:0]            read_addr;
  tcpw_pkg::cell_t                        stored;
  logic                                   clr_last;

  assign stored   = tcpw_pkg::cell_t'(mem_rdata);
  assign accept   = start && (state == tcpw_pkg::ST_IDLE);
  assign busy     = (state != tcpw_pkg::ST_IDLE);
  assign clr_last = (clr_addr == tcpw_pkg::ADDR_W'(tcpw_pkg::CELL_COUNT - 1));

  // Request decode: pick the cursor and row of the run this request belongs to, and the read address.
  always_comb begin
    cur        = req.run_start ? {req.column[15], req.column} : cursor;
    start_live = !req.row[15] && ($unsigned(req.row) < 16'(size.eff_rows));
    live       = req.run_start ? start_live : run_live;
    row_idx    = req.run_start ? req.row[tcpw_pkg::ROW_IDX_W-1:0] : run_row;
    is_wide    = req.char_code > tcpw_pkg::WIDE_ABOVE;
    cur_step   = cur + (is_wide ? 17'sd2 : 17'sd1);
    at_edge    = !cur[tcpw_pkg::CUR_W-1] && (cur[15:0] >= 16'(size.eff_cols));
    row_ok     = 16'(row_idx) < 16'(size.eff_rows);
    fits       = !is_wide || ((17'(cur[15:0]) + 17'd1) < 17'(size.eff_cols));
    put        = live && !at_edge && !cur[tcpw_pkg::CUR_W-1] && row_ok && fits;
    draw_addr  = tcpw_pkg::cell_addr(row_idx, cur[tcpw_pkg::COL_IDX_W-1:0]);
    read_ok    = !req.column[15] && ($unsigned(req.column) < 16'(size.eff_cols)) &&
                 !req.row[15] && ($unsigned(req.row) < 16'(size.eff_rows));
    read_addr  = tcpw_pkg::cell_addr(req.row[tcpw_pkg::ROW_IDX_W-1:0],
                                     req.column[tcpw_pkg::COL_IDX_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcpw_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    mem_req.we     = 1'b0;
    mem_req.addr   = wr_addr;
    mem_req.wdata  = wr_cell;
    case (state)
      tcpw_pkg::ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_addr;
        mem_req.wdata = tcpw_pkg::cleared_cell();
        if (clr_last) begin
          state_next = tcpw_pkg::ST_IDLE;
        end
      end
      tcpw_pkg::ST_IDLE: begin
        mem_req.addr = (req.opcode == tcpw_pkg::OP_READ) ? read_addr : draw_addr;
        if (start) begin
          case (req.opcode)
            tcpw_pkg::OP_CLEAR: state_next = tcpw_pkg::ST_CLEAR;
            tcpw_pkg::OP_DRAW:  state_next = put ? tcpw_pkg::ST_CHECK : tcpw_pkg::ST_IDLE;
            tcpw_pkg::OP_READ:  state_next = tcpw_pkg::ST_READ;
            default:            state_next = tcpw_pkg::ST_IDLE;
          endcase
        end
      end
      tcpw_pkg::ST_CHECK: begin
        // Stored priority above the request keeps the cell.
        mem_req.we            = !($signed(stored.prio) > $signed(wr_cell.prio));
        mem_req.wdata.leading = wr_wide;
        if (mem_req.we && wr_wide) begin
          state_next = tcpw_pkg::ST_TRAIL;
        end else begin
          state_next = tcpw_pkg::ST_IDLE;
        end
      end
      tcpw_pkg::ST_TRAIL: begin
        mem_req.we             = 1'b1;
        mem_req.addr           = wr_addr + tcpw_pkg::ADDR_W'(1);
        mem_req.wdata.trailing = 1'b1;
        state_next             = tcpw_pkg::ST_IDLE;
      end
      tcpw_pkg::ST_READ: begin
        state_next = tcpw_pkg::ST_IDLE;
      end
      default: begin
        state_next = tcpw_pkg::ST_IDLE;
      end
    endcase
  end

  // Run and sweep control.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      cursor       <= '0;
      run_row      <= '0;
      run_live     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == tcpw_pkg::ST_READ);
      if (state == tcpw_pkg::ST_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + tcpw_pkg::ADDR_W'(1);
      end
      if (accept && (req.opcode == tcpw_pkg::OP_CLEAR)) begin
        run_live <= 1'b0;
      end
      if (accept && (req.opcode == tcpw_pkg::OP_DRAW)) begin
        if (req.run_start) begin
          run_row <= req.row[tcpw_pkg::ROW_IDX_W-1:0];
        end
        // Advance past drawn and skipped cells; drop the run at the right edge.
        cursor   <= (live && !at_edge) ? cur_step : cur;
        run_live <= live && !at_edge;
      end
    end
  end

  // Request payload and read result.
  always_ff @(posedge clk) begin
    if (accept) begin
      wr_addr            <= draw_addr;
      wr_cell.char_code  <= req.char_code;
      wr_cell.trailing   <= 1'b0;
      wr_cell.leading    <= 1'b0;
      wr_cell.background <= req.background;
      wr_cell.foreground <= req.foreground;
      wr_cell.prio       <= req.priority_req;
      wr_wide            <= is_wide;
      rd_oor             <= !read_ok;
    end
    if (state == tcpw_pkg::ST_READ) begin
      if (rd_oor) begin
        result.cell_char       <= tcpw_pkg::SPACE_CODE;
        result.cell_foreground <= '0;
        result.cell_background <= '0;
        result.cell_leading    <= 1'b0;
        result.cell_trailing   <= 1'b0;
        result.cell_priority   <= tcpw_pkg::CLEAR_PRIO;
      end else begin
        result.cell_char       <= stored.char_code;
        result.cell_foreground <= stored.foreground;
        result.cell_background <= stored.background;
        result.cell_leading    <= stored.leading;
        result.cell_trailing   <= stored.trailing;
        result.cell_priority   <= stored.prio;
      end
    end
  end

`ifndef SYNTHESIS
  a_trail_after_lead: assert property (@(posedge clk) disable iff (rst)
    (state == tcpw_pkg::ST_TRAIL) |-> $past(mem_req.we && mem_req.wdata.leading))
    else $error("trailing write without a leading write");

  a_result_after_read: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == tcpw_pkg::ST_READ))
    else $error("result strobe without a read");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == tcpw_pkg::ST_CLEAR || state == tcpw_pkg::ST_CHECK ||
                    state == tcpw_pkg::ST_TRAIL))
    else $error("store written outside a write state");

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (state == tcpw_pkg::ST_CLEAR && clr_last) |=> (state == tcpw_pkg::ST_IDLE && clr_addr == '0))
    else $error("clear sweep did not finish cleanly");

  a_clear_ends_run: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == tcpw_pkg::OP_CLEAR) |=> !run_live)
    else $error("run still live after clear");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/text_cell_priority_writer_top.sv
// A read's result strobe rises with the result register, loaded from the store's read data.
// Busy stays high through the read state after a read or the check state after a drawn
// narrow character, through the check and trailing states after a drawn wide one that
// passes its priority test (the check state alone when it fails), not after skipped draws.
// A clear request walks all 8192 cells at one per cycle, busy throughout.
// Reset runs the same clearing pass; the results cannot be stalled.
`default_nettype none

module text_cell_priority_writer_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire tcpw_pkg::req_t     req,
  output logic                    result_valid,
  output tcpw_pkg::rsp_t          result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire tcpw_pkg::cfg_reg_t cfg_index,
  input  wire logic [7:0]         cfg_data
);

  tcpw_pkg::size_t                size;
  tcpw_pkg::mem_req_t             mem_req;
  logic [tcpw_pkg::CELL_W-1:0]    mem_rdata;

  tcpw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .size      (size)
  );

  tcpw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .busy         (busy),
    .size         (size),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata),
    .result_valid (result_valid),
    .result       (result)
  );

  tcpw_ram #(
    .WIDTH (tcpw_pkg::CELL_W),
    .DEPTH (tcpw_pkg::CELL_COUNT)
  ) u_cell_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the text cell priority writer: directed cases, then random runs.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpw_pkg::*;

  localparam logic [1:0] OP_RESERVED  = 2'd3;
  localparam int         SETTLE_LIMIT = 20000;
  localparam int         WATCHDOG_NS  = 5_000_000;
  localparam int         TAIL_CYCLES  = 4;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  req_t     req;
  logic     result_valid;
  rsp_t     result;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_reg_t cfg_index;
  logic [7:0] cfg_data;

  // Frame predictor state
  cell_t      frame_model [CELL_COUNT];
  int         cursor_col;
  int         run_row;
  bit         run_active;
  logic [7:0] cols_reg;
  logic [6:0] rows_reg;
  rsp_t       pending_reads[$];

  int items_sent;
  int reads_checked;
  int clears_seen;
  int cfg_writes;
  int mismatch_count;
  bit gaps_on = 1'b1;

  text_cell_priority_writer_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int visible_cols();
    return (cols_reg < MAX_COLUMNS) ? int'(cols_reg) : MAX_COLUMNS;
  endfunction

  function automatic int visible_rows();
    return (rows_reg < MAX_ROWS) ? int'(rows_reg) : MAX_ROWS;
  endfunction

  function automatic cell_t empty_cell();
    cell_t c;
    c           = '0;
    c.char_code = SPACE_CODE;
    c.prio      = CLEAR_PRIO;
    return c;
  endfunction

  function automatic void wipe_frame();
    for (int i = 0; i < CELL_COUNT; i++) frame_model[i] = empty_cell();
  endfunction

  function automatic void paint_cell(int col, int rw, req_t r);
    int    idx;
    cell_t c;
    if (col < 0 || col >= visible_cols() || rw < 0 || rw >= visible_rows()) return;
    idx = rw * MAX_COLUMNS + col;
    if ($signed(frame_model[idx].prio) > $signed(r.priority_req)) return;
    c            = '0;
    c.char_code  = r.char_code;
    c.foreground = r.foreground;
    c.background = r.background;
    c.prio       = r.priority_req;
    if (r.char_code > WIDE_ABOVE) begin
      // second half takes the write without its own priority test
      if (col + 1 < visible_cols()) begin
        c.leading            = 1'b1;
        frame_model[idx]     = c;
        c.leading            = 1'b0;
        c.trailing           = 1'b1;
        frame_model[idx + 1] = c;
      end
    end else begin
      frame_model[idx] = c;
    end
  endfunction

  // Advance the frame predictor by one accepted request
  function automatic void apply_to_frame(req_t r);
    int    col_s;
    int    row_s;
    int    width_cells;
    cell_t c;
    rsp_t  rd;
    col_s       = $signed(r.column);
    row_s       = $signed(r.row);
    width_cells = (r.char_code > WIDE_ABOVE) ? 2 : 1;
    case (r.opcode)
      OP_CLEAR: begin
        wipe_frame();
        run_active = 1'b0;
        clears_seen++;
      end
      OP_DRAW: begin
        if (r.run_start) begin
          cursor_col = col_s;
          run_row    = row_s;
          run_active = (row_s >= 0 && row_s < visible_rows());
        end
        if (run_active) begin
          if (cursor_col >= visible_cols()) begin
            run_active = 1'b0;
          end else begin
            if (cursor_col >= 0) paint_cell(cursor_col, run_row, r);
            cursor_col += width_cells;
          end
        end
      end
      OP_READ: begin
        c = empty_cell();
        if (col_s >= 0 && col_s < visible_cols() && row_s >= 0 && row_s < visible_rows())
          c = frame_model[row_s * MAX_COLUMNS + col_s];
        rd.cell_char       = c.char_code;
        rd.cell_foreground = c.foreground;
        rd.cell_background = c.background;
        rd.cell_leading    = c.leading;
        rd.cell_trailing   = c.trailing;
        rd.cell_priority   = c.prio;
        pending_reads.push_back(rd);
      end
      default: ;
    endcase
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int any16();
    logic signed [15:0] v;
    v = 16'($urandom);
    return v;
  endfunction

  function automatic req_t noise_bits();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(req_t)-1:0];
  endfunction

  function automatic req_t draw_item(bit first, int col, int rw, logic [15:0] code, int prio);
    req_t r;
    r              = noise_bits();
    r.opcode       = OP_DRAW;
    r.run_start    = first;
    r.char_code    = code;
    r.priority_req = 16'(prio);
    if (first) begin
      r.column = 16'(col);
      r.row    = 16'(rw);
    end
    return r;
  endfunction

  function automatic req_t read_item(int col, int rw);
    req_t r;
    r        = noise_bits();
    r.opcode = OP_READ;
    r.column = 16'(col);
    r.row    = 16'(rw);
    return r;
  endfunction

  function automatic req_t clear_item();
    req_t r;
    r        = noise_bits();
    r.opcode = OP_CLEAR;
    return r;
  endfunction

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'(rand_between(32, 126));
      6, 7, 8:          return 16'(rand_between(128, 65535));
      default:          return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_prio(int base);
    case ($urandom_range(0, 9))
      0:       return rand_between(-3, 3);
      1:       return any16();
      default: return base;
    endcase
  endfunction

  function automatic string cell_text(rsp_t c);
    return $sformatf("char=%h fg=%h bg=%h lead=%b trail=%b prio=%0d", c.cell_char,
                     c.cell_foreground, c.cell_background, c.cell_leading, c.cell_trailing,
                     $signed(c.cell_priority));
  endfunction

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && result_valid) begin
      if (pending_reads.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no read pending: %s", $time, cell_text(result));
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (result.cell_char !== want.cell_char ||
            result.cell_foreground !== want.cell_foreground ||
            result.cell_background !== want.cell_background ||
            result.cell_leading !== want.cell_leading ||
            result.cell_trailing !== want.cell_trailing ||
            result.cell_priority !== want.cell_priority) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: read mismatch, expected %s, got %s", $time, cell_text(want),
                     cell_text(result));
        end
      end
    end
  end

  task automatic send(req_t r);
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_to_frame(r);
    items_sent++;
  endtask

  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      req   <= noise_bits();
    end
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 19));
  endtask

  // Drop start, wait out pending reads and any draw or clear still in flight
  task automatic settle();
    int guard;
    guard = 0;
    hold_off(1);
    while ((pending_reads.size() != 0 || busy) && guard < SETTLE_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_COLUMNS) cols_reg = value;
    else rows_reg = value[6:0];
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_screen(logic [7:0] cols, logic [7:0] rows);
    settle();
    write_register(REG_COLUMNS, cols);
    write_register(REG_ROWS, rows);
  endtask

  task automatic test_cleared_frame();
    send(read_item(0, 0));
    send(read_item(79, 24));
    send(read_item(80, 0));
    send(read_item(0, -32768));
    send(read_item(32767, 32767));
  endtask

  task automatic test_priority_and_wide();
    send(draw_item(1, 0, 0, 16'h0041, 5));
    send(draw_item(0, 0, 0, WIDE_ABOVE, 32767));
    send(draw_item(1, 0, 0, 16'h0043, 4));
    // equal priority wins cell 0, and the trailing half overwrites a higher priority
    send(draw_item(1, 0, 0, 16'd128, 5));
    send(read_item(0, 0));
    send(read_item(1, 0));
    send(read_item(2, 0));
  endtask

  task automatic test_run_edges();
    req_t r;
    send(draw_item(1, 78, 24, 16'h0058, -32768));
    send(draw_item(0, 0, 0, 16'hFFFF, 0));
    send(draw_item(0, 0, 0, 16'h0059, 0));
    send(draw_item(0, 0, 0, 16'h005A, 0));
    send(read_item(78, 24));
    send(read_item(79, 24));
    send(draw_item(1, -1, 3, 16'h0061, 1));
    send(draw_item(0, 0, 0, 16'hABCD, 1));
    send(read_item(0, 3));
    send(read_item(1, 3));
    send(draw_item(1, -32768, 2, 16'h0062, 1));
    send(draw_item(1, 32767, 2, 16'h0063, 1));
    send(draw_item(1, 0, 32767, 16'h0071, 1));
    send(draw_item(1, 0, -32768, 16'h0072, 1));
    send(draw_item(1, 0, 25, 16'h0073, 1));
    send(draw_item(0, 0, 0, 16'h0074, 1));
    r = read_item(0, 0);
    r.opcode = OP_RESERVED;
    send(r);
  endtask

  task automatic test_clear_ends_run();
    send(draw_item(1, 5, 5, 16'h006B, 0));
    send(clear_item());
    send(draw_item(0, 0, 0, 16'h006D, 0));
    send(read_item(5, 5));
    send(read_item(6, 5));
  endtask

  task automatic test_screen_size();
    set_screen(8'd0, 8'd0);
    send(draw_item(1, 0, 0, 16'h007A, 0));
    send(read_item(0, 0));
    set_screen(8'hFF, 8'hFF);
    send(draw_item(1, 127, 63, 16'h007E, 32767));
    send(read_item(127, 63));
    send(draw_item(1, 10, 40, 16'h0070, 0));
    // shrink the screen under a live run
    settle();
    write_register(REG_ROWS, 8'd20);
    send(draw_item(0, 0, 0, 16'h0071, 0));
    settle();
    write_register(REG_ROWS, 8'd64);
    send(read_item(10, 40));
    send(read_item(11, 40));
    set_screen(8'd80, 8'd25);
  endtask

  task automatic random_run();
    int rw;
    int col;
    int len;
    int base;
    case ($urandom_range(0, 19))
      0:       rw = $urandom_range(0, 1) ? -1 : visible_rows();
      1:       rw = any16();
      default: rw = (visible_rows() > 0) ? rand_between(0, visible_rows() - 1) : 0;
    endcase
    case ($urandom_range(0, 9))
      0:       col = rand_between(visible_cols() - 3, visible_cols() + 1);
      1:       col = any16();
      default: col = rand_between(-4, visible_cols() + 1);
    endcase
    base = rand_between(-3, 3);
    len  = rand_between(1, 14);
    for (int i = 0; i < len; i++) begin
      send(draw_item(i == 0, col, rw, pick_code(), pick_prio(base)));
      maybe_gap();
    end
    repeat (rand_between(1, 4)) begin
      send(read_item(rand_between(col - 1, col + 2 * len), rw));
      maybe_gap();
    end
  endtask

  task automatic test_random_traffic();
    int   pick;
    int   goal;
    req_t r;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       set_screen(8'd80, 8'd25);
        1:       set_screen(8'd128, 8'd64);
        2:       set_screen(8'd255, 8'd127);
        3:       set_screen(8'd1, 8'd1);
        4:       set_screen(8'd2, 8'd3);
        7:       set_screen(8'd40, 8'd10);
        default: set_screen(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
      endcase
      gaps_on = (phase < 7);
      goal    = items_sent + 96;
      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          random_run();
        end else if (pick < 87) begin
          r = noise_bits();
          // hold clears rare, each one walks the whole store
          if (r.opcode == OP_CLEAR && $urandom_range(0, 9) != 0) r.opcode = OP_DRAW;
          send(r);
          maybe_gap();
        end else if (pick < 89) begin
          send(clear_item());
        end else begin
          send(read_item(rand_between(-1, visible_cols()), rand_between(-1, visible_rows())));
          maybe_gap();
        end
      end
    end
  endtask

  initial begin
    WATCHDOG: begin
      #(WATCHDOG_NS);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_COLUMNS;
    cfg_data  = '0;
    wipe_frame();
    cursor_col = 0;
    run_row    = 0;
    run_active = 1'b0;
    cols_reg   = 8'd80;
    rows_reg   = 7'd25;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_cleared_frame();
    test_priority_and_wide();
    test_run_edges();
    test_clear_ends_run();
    test_screen_size();
    test_random_traffic();
    settle();

    $display("Sent %0d requests including %0d clears; checked %0d reads.", items_sent,
             clears_seen, reads_checked);
    $display("Made %0d register writes over screens from 0x0 to 128x64; %0d mismatches.",
             cfg_writes, mismatch_count);
    if (mismatch_count == 0 && pending_reads.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
